// ===== rtl/core/kmp_pkg.sv =====
package kmp_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int CHAR_BITS_DEF   = 16;

    localparam int PARTIAL_W = 6;
    localparam int COUNT_W   = 32;
    localparam int STATUS_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_NOPAT = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_CHK
    } state_t;

endpackage

// ===== rtl/core/kmp_in_if.sv =====
interface kmp_in_if #(
    parameter int CHAR_BITS = kmp_pkg::CHAR_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic                 first;
    logic [CHAR_BITS-1:0] ch;

    modport source (output valid, output mode, output first, output ch, input ready);
    modport sink   (input valid, input mode, input first, input ch, output ready);
endinterface

// ===== rtl/core/kmp_out_if.sv =====
interface kmp_out_if;
    logic                           valid;
    logic                           ready;
    logic                           matched;
    logic [kmp_pkg::PARTIAL_W-1:0]  partial_len;
    logic [kmp_pkg::COUNT_W-1:0]    consumed;
    logic [kmp_pkg::COUNT_W-1:0]    keep_from;
    logic [kmp_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output matched, output partial_len, output consumed,
                    output keep_from, output status, input ready);
    modport sink   (input valid, input matched, input partial_len, input consumed,
                    input keep_from, input status, output ready);
endinterface

// ===== rtl/core/kmp_stream_matcher_top.sv =====
// An accepted transaction enters S_CHK and makes F KMP fallback steps before its result is written
// to the result register, one failure-table read per cycle through the synchronous pattern and
// failure memories. Pattern-full, first-pattern-character and no-pattern items have F = 0.
// The input takes a new transaction only in S_IDLE, once the previous one has left S_CHK; a new one is
// taken while the previous result still waits, but it then stalls until the output register is read.
// Reset (async, active low) clears control, length, prefix and count; memories are not cleared.
module kmp_stream_matcher_top #(
    parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF,
    parameter int CHAR_BITS   = kmp_pkg::CHAR_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    kmp_in_if.sink     item,
    kmp_out_if.source  result
);
    import kmp_pkg::*;

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic [CHAR_BITS-1:0] pat_mem  [MAX_PATTERN];
    logic [AW-1:0]        fail_mem [MAX_PATTERN];

    state_t               state_reg, state_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [AW-1:0]        bp_reg, bp_next;
    logic [AW-1:0]        ml_reg, ml_next;
    logic [COUNT_W-1:0]   tc_reg, tc_next;
    logic                 ov_reg, ov_next;

    // per-transaction working registers
    logic                 mode_reg, mode_next;
    logic                 skip_reg, skip_next;
    status_t              stat_reg, stat_next;
    logic [CHAR_BITS-1:0] ch_reg, ch_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        k_reg, k_next;

    // output register
    logic                 o_matched_reg, o_matched_next;
    logic [PARTIAL_W-1:0] o_partial_reg, o_partial_next;
    logic [COUNT_W-1:0]   o_consumed_reg, o_consumed_next;
    logic [COUNT_W-1:0]   o_keep_reg, o_keep_next;
    status_t              o_status_reg, o_status_next;

    logic [CHAR_BITS-1:0] pat_rd_reg;
    logic [AW-1:0]        fail_rd_reg;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        fail_addr;
    logic                 pat_we;
    logic                 fail_we;
    logic [AW-1:0]        fail_wdata;

    logic                 accept;
    logic                 out_free;
    logic [LW-1:0]        eff_len;
    logic [AW-1:0]        k0;
    logic [COUNT_W-1:0]   tc_base;
    logic                 pm;
    logic [LW-1:0]        knew;
    logic                 hit;
    logic [AW-1:0]        ml_new;
    logic [31:0]          ml_wide;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !ov_reg || result.ready;
    assign pm         = (pat_rd_reg == ch_reg);
    assign fail_addr  = rd_addr - AW'(1);

    assign result.valid       = ov_reg;
    assign result.matched     = o_matched_reg;
    assign result.partial_len = o_partial_reg;
    assign result.consumed    = o_consumed_reg;
    assign result.keep_from   = o_keep_reg;
    assign result.status      = o_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        bp_next         = bp_reg;
        ml_next         = ml_reg;
        tc_next         = tc_reg;
        ov_next         = ov_reg && !result.ready;
        mode_next       = mode_reg;
        skip_next       = skip_reg;
        stat_next       = stat_reg;
        ch_next         = ch_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        o_matched_next  = o_matched_reg;
        o_partial_next  = o_partial_reg;
        o_consumed_next = o_consumed_reg;
        o_keep_next     = o_keep_reg;
        o_status_next   = o_status_reg;
        rd_addr         = k_reg;
        pat_we          = 1'b0;
        fail_we         = 1'b0;
        fail_wdata      = '0;
        eff_len         = (!item.mode && item.first) ? '0 : len_reg;
        tc_base         = item.first ? '0 : tc_reg;
        k0              = '0;
        knew            = '0;
        hit             = 1'b0;
        ml_new          = '0;
        ml_wide         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    mode_next  = item.mode;
                    ch_next    = item.ch;
                    idx_next   = AW'(eff_len);
                    stat_next  = STAT_OK;
                    state_next = S_CHK;
                    if (!item.mode)
                    begin
                        k0       = item.first ? '0 : bp_reg;
                        len_next = eff_len;
                        if (eff_len == LW'(MAX_PATTERN))
                        begin
                            skip_next = 1'b1;
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            skip_next = (eff_len == '0);
                            pat_we    = 1'b1;
                        end
                    end
                    else
                    begin
                        k0      = item.first ? '0 : ml_reg;
                        tc_next = (tc_base == COUNT_MAX) ? tc_base : tc_base + 1'b1;
                        skip_next = (len_reg == '0);
                        if (len_reg == '0)
                            stat_next = STAT_NOPAT;
                    end
                    k_next  = k0;
                    rd_addr = k0;
                end
            end
            S_CHK:
            begin
                if (!skip_reg && !pm && k_reg != '0)
                begin
                    // mismatch: fall back through the failure table
                    k_next  = fail_rd_reg;
                    rd_addr = fail_rd_reg;
                end
                else
                begin
                    knew = (!skip_reg && pm) ? LW'(k_reg) + 1'b1 : '0;
                    if (mode_reg && !skip_reg && knew >= len_reg)
                        hit = 1'b1;
                    if (mode_reg && !skip_reg && !hit)
                        ml_new = AW'(knew);
                    ml_wide = 32'(ml_new);
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                        ml_next    = ml_new;
                        if (!mode_reg && stat_reg != STAT_FULL)
                        begin
                            fail_we    = 1'b1;
                            fail_wdata = AW'(knew);
                            bp_next    = AW'(knew);
                            len_next   = LW'(idx_reg) + 1'b1;
                        end
                        ov_next         = 1'b1;
                        o_matched_next  = hit;
                        o_partial_next  = ml_wide[PARTIAL_W-1:0];
                        o_consumed_next = tc_reg;
                        o_keep_next     = tc_reg - COUNT_W'(ml_new);
                        o_status_next   = stat_reg;
                    end
                    else
                    begin
                        rd_addr = k_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (!accept && state_reg == S_IDLE)
        begin
            state_next = S_IDLE;
            len_next   = len_reg;
            tc_next    = tc_reg;
            pat_we     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            bp_reg    <= '0;
            ml_reg    <= '0;
            tc_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            bp_reg    <= bp_next;
            ml_reg    <= ml_next;
            tc_reg    <= tc_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        skip_reg       <= skip_next;
        stat_reg       <= stat_next;
        ch_reg         <= ch_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        o_matched_reg  <= o_matched_next;
        o_partial_reg  <= o_partial_next;
        o_consumed_reg <= o_consumed_next;
        o_keep_reg     <= o_keep_next;
        o_status_reg   <= o_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (pat_we)
            pat_mem[idx_next] <= item.ch;
        pat_rd_reg <= pat_mem[rd_addr];
    end

    // a read at k-1 with k zero wraps; its data is never used
    always_ff @(posedge clk)
    begin
        if (fail_we)
            fail_mem[idx_reg] <= fail_wdata;
        fail_rd_reg <= fail_mem[fail_addr];
    end

endmodule

// ===== dv/kmp_stream_matcher_top_test.sv =====
`timescale 1ns / 1ps

module kmp_stream_matcher_top_test;

    import kmp_pkg::*;

    localparam int MAX_PAT    = MAX_PATTERN_DEF;
    localparam int CH_W       = CHAR_BITS_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int ITEM_GOAL  = 1150;
    localparam int DRAIN_WAIT = 2 * MAX_PAT + 20;

    localparam logic MODE_PAT  = 1'b0;
    localparam logic MODE_TEXT = 1'b1;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_style_t;

    typedef struct packed {
        logic                 matched;
        logic [PARTIAL_W-1:0] partial_len;
        logic [COUNT_W-1:0]   consumed;
        logic [COUNT_W-1:0]   keep_from;
        status_t              status;
    } scan_result_t;

    logic clk;
    logic rst_n;

    kmp_in_if #(.CHAR_BITS(CH_W)) item_if ();
    kmp_out_if                    result_if ();

    kmp_stream_matcher_top #(
        .MAX_PATTERN(MAX_PAT),
        .CHAR_BITS  (CH_W)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if),
        .result(result_if)
    );

    // predictor state
    logic [CH_W-1:0]      pat_mem  [MAX_PAT];
    logic [PARTIAL_W-1:0] fail_mem [MAX_PAT];
    logic [6:0]           pat_len;
    logic [PARTIAL_W-1:0] build_k;
    logic [PARTIAL_W-1:0] scan_len;
    logic [COUNT_W-1:0]   text_cnt;

    scan_result_t scan_results_due [$];
    int           error_count;
    int           items_sent;
    int           burst_left;
    int           hold_request;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [6:0] kmp_advance(input logic [6:0] k, input logic [CH_W-1:0] c);
        logic [6:0] j;
        j = k;
        while (j > 0 && pat_mem[j[5:0]] != c)
            j = {1'b0, fail_mem[j[5:0] - 6'd1]};
        if (j < MAX_PAT && pat_mem[j[5:0]] == c)
            j = j + 7'd1;
        return j;
    endfunction

    function automatic scan_result_t predict_scan(input logic m, input logic f,
                                                  input logic [CH_W-1:0] c);
        scan_result_t r;
        logic [6:0]   k;
        r        = '0;
        r.status = STAT_OK;
        if (m == MODE_PAT)
        begin
            if (f)
            begin
                pat_len = '0;
                build_k = '0;
            end
            if (pat_len >= MAX_PAT)
                r.status = STAT_FULL;
            else
            begin
                pat_mem[pat_len[5:0]] = c;
                if (pat_len == 0)
                    build_k = '0;
                else
                begin
                    k       = kmp_advance({1'b0, build_k}, c);
                    build_k = k[5:0];
                end
                fail_mem[pat_len[5:0]] = build_k;
                pat_len = pat_len + 7'd1;
            end
            // any pattern change restarts matching
            scan_len = '0;
        end
        else
        begin
            if (f)
            begin
                text_cnt = '0;
                scan_len = '0;
            end
            if (text_cnt != COUNT_MAX)
                text_cnt = text_cnt + 1;
            if (pat_len == 0)
            begin
                scan_len = '0;
                r.status = STAT_NOPAT;
            end
            else
            begin
                k = kmp_advance({1'b0, scan_len}, c);
                if (k >= pat_len)
                begin
                    r.matched = 1'b1;
                    k         = '0;
                end
                scan_len = k[5:0];
            end
        end
        r.partial_len = scan_len;
        r.consumed    = text_cnt;
        r.keep_from   = text_cnt - scan_len;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0h expected %0h", $time, field, got, want);
        error_count++;
    endtask

    // one input transaction, with bursty gaps in front of it
    task automatic send_char(input logic m, input logic f, input logic [CH_W-1:0] c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_if.valid <= 1'b1;
        item_if.mode  <= m;
        item_if.first <= f;
        item_if.ch    <= c;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        scan_results_due = {scan_results_due, predict_scan(m, f, c)};
        items_sent++;
    endtask

    task automatic test_no_pattern();
        send_char(MODE_TEXT, 1'b1, 16'hFFFF);
        send_char(MODE_TEXT, 1'b0, 16'h0000);
        send_char(MODE_TEXT, 1'b0, 16'h1234);
        send_char(MODE_TEXT, 1'b1, 16'hA5A5);
    endtask

    task automatic test_basic_match();
        send_char(MODE_PAT,  1'b1, 16'hFFFF);
        send_char(MODE_PAT,  1'b0, 16'h0000);
        send_char(MODE_PAT,  1'b0, 16'hFFFF);
        send_char(MODE_TEXT, 1'b1, 16'hFFFF);
        send_char(MODE_TEXT, 1'b0, 16'h0000);
        send_char(MODE_TEXT, 1'b0, 16'hFFFF);
        send_char(MODE_TEXT, 1'b0, 16'h0000);
        send_char(MODE_TEXT, 1'b0, 16'hFFFF);
        send_char(MODE_TEXT, 1'b0, 16'h0000);
        send_char(MODE_TEXT, 1'b0, 16'hFFFF);
        send_char(MODE_TEXT, 1'b0, 16'hFFFF);
        send_char(MODE_TEXT, 1'b0, 16'h0000);
        // append mid-string: partial drops, count is kept
        send_char(MODE_PAT,  1'b0, 16'h5555);
        send_char(MODE_TEXT, 1'b0, 16'hFFFF);
        send_char(MODE_TEXT, 1'b0, 16'h0000);
        send_char(MODE_TEXT, 1'b0, 16'hFFFF);
        send_char(MODE_TEXT, 1'b0, 16'hFFFF);
        send_char(MODE_TEXT, 1'b0, 16'h0000);
        send_char(MODE_TEXT, 1'b0, 16'hFFFF);
        send_char(MODE_TEXT, 1'b0, 16'h5555);
        send_char(MODE_TEXT, 1'b1, 16'h0000);
    endtask

    task automatic test_pattern_capacity();
        int              i;
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        a = CH_W'($urandom_range(0, 65535));
        b = a ^ 16'h8001;
        for (i = 0; i < MAX_PAT; i++)
            send_char(MODE_PAT, i == 0, a);
        send_char(MODE_PAT, 1'b0, b);
        send_char(MODE_PAT, 1'b0, a);
        for (i = 0; i < MAX_PAT - 1; i++)
            send_char(MODE_TEXT, i == 0, a);
        // falls back through the whole table
        send_char(MODE_TEXT, 1'b0, b);
        for (i = 0; i < MAX_PAT + 1; i++)
            send_char(MODE_TEXT, 1'b0, a);
        send_char(MODE_PAT, 1'b1, b);
        send_char(MODE_TEXT, 1'b0, b);
    endtask

    task automatic test_output_backpressure();
        int              i;
        logic [CH_W-1:0] a;
        a = CH_W'($urandom_range(0, 65535));
        hold_request = 300;
        send_char(MODE_PAT, 1'b1, a);
        send_char(MODE_PAT, 1'b0, ~a);
        for (i = 0; i < 40; i++)
            send_char(MODE_TEXT, i == 0, ($urandom_range(0, 1) == 0) ? a : ~a);
    endtask

    task automatic test_random_streams(input int goal);
        logic [CH_W-1:0] alpha [4];
        logic [CH_W-1:0] pat   [MAX_PAT];
        int              n_alpha;
        int              plen;
        int              tlen;
        int              i;
        int              j;
        int              pick;
        while (items_sent < goal)
        begin
            n_alpha = $urandom_range(1, 4);
            for (i = 0; i < 4; i++)
                alpha[i] = CH_W'($urandom_range(0, 65535));
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_PAT) : $urandom_range(1, 8);
            for (i = 0; i < plen; i++)
                pat[i] = alpha[$urandom_range(0, n_alpha - 1)];
            // mostly a fresh pattern; now and then extend the old one
            for (i = 0; i < plen; i++)
                send_char(MODE_PAT, (i == 0) && ($urandom_range(0, 7) != 0), pat[i]);
            tlen = $urandom_range(8, 60);
            i = 0;
            while (i < tlen)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                begin
                    for (j = 0; j < plen; j++)
                        send_char(MODE_TEXT, (i == 0) && (j == 0) && pick[0], pat[j]);
                    i += plen;
                end
                else if (pick < 28)
                begin
                    send_char(MODE_TEXT, 1'b0, CH_W'($urandom_range(0, 65535)));
                    i++;
                end
                else if (pick < 31)
                begin
                    send_char(MODE_TEXT, 1'b1, alpha[$urandom_range(0, n_alpha - 1)]);
                    i++;
                end
                else if (pick < 33)
                begin
                    send_char(MODE_PAT, 1'b0, alpha[$urandom_range(0, n_alpha - 1)]);
                    i++;
                end
                else
                begin
                    send_char(MODE_TEXT, (i == 0) && pick[0], alpha[$urandom_range(0, n_alpha - 1)]);
                    i++;
                end
            end
        end
    endtask

    initial
    begin : receiver
        rx_style_t style;
        int        left;
        int        hold;
        int        phase;
        result_if.ready = 1'b0;
        style = RX_OPEN;
        left  = 0;
        phase = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold         = hold_request;
                hold_request = 0;
                result_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    style = rx_style_t'($urandom_range(0, 3));
                    left  = $urandom_range(20, 200);
                end
                left--;
                phase++;
                case (style)
                    RX_OPEN:     result_if.ready <= 1'b1;
                    RX_COIN:     result_if.ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE:   result_if.ready <= ($urandom_range(0, 7) == 0);
                    RX_PERIODIC: result_if.ready <= (phase % 4 != 3);
                    default:     result_if.ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (scan_results_due.size() == 0)
                report_mismatch("unexpected result, consumed", result_if.consumed, '0);
            else
            begin
                want = scan_results_due.pop_front();
                if (result_if.matched !== want.matched)
                    report_mismatch("matched", result_if.matched, want.matched);
                if (result_if.partial_len !== want.partial_len)
                    report_mismatch("partial_len", result_if.partial_len, want.partial_len);
                if (result_if.consumed !== want.consumed)
                    report_mismatch("consumed", result_if.consumed, want.consumed);
                if (result_if.keep_from !== want.keep_from)
                    report_mismatch("keep_from", result_if.keep_from, want.keep_from);
                if (result_if.status !== want.status)
                    report_mismatch("status", result_if.status, want.status);
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int i;
        rst_n         = 1'b0;
        item_if.valid = 1'b0;
        item_if.mode  = MODE_PAT;
        item_if.first = 1'b0;
        item_if.ch    = '0;
        error_count   = 0;
        items_sent    = 0;
        burst_left    = 0;
        hold_request  = 0;
        pat_len       = '0;
        build_k       = '0;
        scan_len      = '0;
        text_cnt      = '0;
        for (i = 0; i < MAX_PAT; i++)
        begin
            pat_mem[i]  = '0;
            fail_mem[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_pattern();
        test_basic_match();
        test_pattern_capacity();
        test_output_backpressure();
        test_random_streams(ITEM_GOAL);

        @(posedge clk);
        item_if.valid <= 1'b0;
        while (scan_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/kmp_pkg.sv
rtl/core/kmp_in_if.sv
rtl/core/kmp_out_if.sv
rtl/core/kmp_stream_matcher_top.sv
dv/kmp_stream_matcher_top_test.sv
